// ===== rtl/core/icmp_echo_reply_builder_assert.svh =====
// Assertion macros for the ICMP echo reply builder.
`ifndef ICMP_ECHO_REPLY_BUILDER_ASSERT_SVH
`define ICMP_ECHO_REPLY_BUILDER_ASSERT_SVH

// Concurrent check on clk, disabled in reset.
`define IERB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Output word must hold while the receiver stalls.
`define IERB_ASSERT_HOLD(label, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (out_valid && !out_ready) |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/core/ierb_pkg.sv =====
package ierb_pkg;

    localparam logic [2:0] VERDICT_REPLY     = 3'd0;
    localparam logic [2:0] VERDICT_MALFORMED = 3'd1;
    localparam logic [2:0] VERDICT_BAD_SUM   = 3'd2;
    localparam logic [2:0] VERDICT_NOT_ECHO  = 3'd3;
    localparam logic [2:0] VERDICT_TRUNCATED = 3'd4;

    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam int         QUEUE_DEPTH_DEF   = 2;

    // Raw facts of one datagram, gathered by the front end.
    typedef struct packed {
        logic [16:0] received;
        logic [5:0]  hlen;
        logic [15:0] total;
        logic [15:0] sum_with;
        logic [15:0] sum_without;
        logic [7:0]  pending;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [31:0] src;
        logic [31:0] dst;
    } dgram_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== rtl/core/ierb_front.sv =====
module ierb_front
    import ierb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       push,
    output dgram_t     push_word
);
    logic [15:0] off_reg, total_reg, sw_reg, so_reg;
    logic [5:0]  hlen_reg;
    logic [7:0]  pend_reg, type_reg, code_reg;
    logic [31:0] src_reg, dst_reg;
    logic [15:0] total_now, sw_n, so_n, idx;
    logic [5:0]  hlen_now;
    logic [7:0]  pend_n, type_n, code_n;
    logic [31:0] src_n, dst_n;
    logic        in_region;

    always_comb
    begin
        hlen_now  = (off_reg == 16'd0) ? {data_byte[3:0], 2'b00} : hlen_reg;
        total_now = total_reg;
        if (off_reg == 16'd2)
            total_now = {data_byte, total_reg[7:0]};
        else if (off_reg == 16'd3)
            total_now = {total_reg[15:8], data_byte};
        src_n = src_reg;
        dst_n = dst_reg;
        if (off_reg >= 16'd12 && off_reg < 16'd16)
            src_n = {src_reg[23:0], data_byte};
        else if (off_reg >= 16'd16 && off_reg < 16'd20)
            dst_n = {dst_reg[23:0], data_byte};
        in_region = (off_reg >= {10'd0, hlen_now}) &&
                    (off_reg < 16'd4 || off_reg < total_now);
        idx    = off_reg - {10'd0, hlen_now};
        type_n = type_reg;
        code_n = code_reg;
        pend_n = pend_reg;
        sw_n   = sw_reg;
        so_n   = so_reg;
        if (in_region)
        begin
            if (idx == 16'd0)
                type_n = data_byte;
            else if (idx == 16'd1)
                code_n = data_byte;
            if (!idx[0])
                pend_n = data_byte;
            else
            begin
                sw_n = oc_add(sw_reg, {pend_reg, data_byte});
                if (idx == 16'd1)
                    so_n = oc_add(so_reg, {8'd0, data_byte});
                else if (idx != 16'd3)
                    so_n = oc_add(so_reg, {pend_reg, data_byte});
            end
        end
        // count kept one bit wider so a saturated offset still reads as received
        push_word = '{received: {1'b0, off_reg} + 17'd1, hlen: hlen_now, total: total_now,
                      sum_with: sw_n, sum_without: so_n, pending: pend_n,
                      msg_type: type_n, msg_code: code_n, src: src_n, dst: dst_n};
        push = in_fire && last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0; total_reg <= '0; sw_reg <= '0; so_reg <= '0;
            hlen_reg <= '0; pend_reg <= '0; type_reg <= '0; code_reg <= '0;
            src_reg <= '0; dst_reg <= '0;
        end
        else if (in_fire)
        begin
            if (last_byte)
            begin
                off_reg <= '0; total_reg <= '0; sw_reg <= '0; so_reg <= '0;
                hlen_reg <= '0; pend_reg <= '0; type_reg <= '0; code_reg <= '0;
                src_reg <= '0; dst_reg <= '0;
            end
            else
            begin
                if (off_reg != 16'hFFFF)
                    off_reg <= off_reg + 16'd1;
                total_reg <= total_now; hlen_reg <= hlen_now;
                sw_reg <= sw_n; so_reg <= so_n; pend_reg <= pend_n;
                type_reg <= type_n; code_reg <= code_n;
                src_reg <= src_n; dst_reg <= dst_n;
            end
        end
    end
endmodule

// ===== rtl/core/ierb_queue.sv =====
module ierb_queue
    import ierb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  dgram_t push_word,
    output logic   full,
    output logic   not_empty,
    input  logic   pop,
    output dgram_t head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    dgram_t          mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

`include "icmp_echo_reply_builder_assert.svh"
    `IERB_ASSERT(a_no_overflow, push |-> (!full || pop), "queue overflow")
    `IERB_ASSERT(a_no_underflow, pop |-> not_empty, "queue underflow")
    `IERB_ASSERT(a_count_bound, cnt_reg <= (AW+1)'(DEPTH), "queue count out of range")
endmodule

// ===== rtl/core/ierb_back.sv =====
module ierb_back
    import ierb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        avail,
    input  dgram_t      head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic [15:0] reply_checksum,
    output logic [31:0] reply_source,
    output logic [31:0] reply_destination,
    output logic [15:0] icmp_length,
    output logic [5:0]  header_length
);
    logic        valid_reg;
    logic [2:0]  v_next;
    logic [15:0] c_next, len_next, sw, so;
    logic        short_tot;

    always_comb
    begin
        short_tot = head.total < {10'd0, head.hlen};
        len_next  = short_tot ? 16'd0 : head.total - {10'd0, head.hlen};
        sw = head.sum_with;
        so = head.sum_without;
        if (len_next[0])
        begin
            sw = oc_add(sw, {head.pending, 8'd0});
            so = oc_add(so, {head.pending, 8'd0});
        end
        c_next = '0;
        priority if (short_tot || len_next < 16'd4)
            v_next = VERDICT_MALFORMED;
        else if (head.received < {1'b0, head.total})
            v_next = VERDICT_TRUNCATED;
        else if (sw != 16'hFFFF)
            v_next = VERDICT_BAD_SUM;
        else if (head.msg_type != ICMP_ECHO_REQUEST || head.msg_code != 8'd0)
            v_next = VERDICT_NOT_ECHO;
        else
        begin
            v_next = VERDICT_REPLY;
            c_next = ~so;
        end
    end

    assign pop       = avail && (!valid_reg || out_ready);
    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            verdict           <= v_next;
            reply_checksum    <= c_next;
            reply_source      <= head.dst;
            reply_destination <= head.src;
            icmp_length       <= len_next;
            header_length     <= head.hlen;
        end
    end

`include "icmp_echo_reply_builder_assert.svh"
    `IERB_ASSERT_HOLD(a_hold, verdict, "result changed while stalled")
    `IERB_ASSERT_HOLD(a_valid_hold, out_valid, "valid dropped while stalled")
    `IERB_ASSERT(a_csum_zero, (out_valid && verdict != VERDICT_REPLY) |-> reply_checksum == 16'd0,
        "checksum on non-reply")
endmodule

// ===== rtl/core/icmp_echo_reply_builder.sv =====
// ICMP echo reply builder: one datagram byte per cycle in unless the queue is full, one verdict word per datagram out.
// Throughput: one byte every cycle unless the queue is full; a back-to-back next datagram follows with no gap.
// Path: the last byte's facts are pushed into a QUEUE_DEPTH-entry queue (two by default), then popped
// into the registered verdict stage that drives out_valid (front end -> queue -> verdict stage).
// Reset (rst_n low, asynchronous) clears offsets, sums, captured fields, queue pointers and out_valid.
module icmp_echo_reply_builder
    import ierb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic [15:0] reply_checksum,
    output logic [31:0] reply_source,
    output logic [31:0] reply_destination,
    output logic [15:0] icmp_length,
    output logic [5:0]  header_length
);
    logic   push, full, not_empty, pop, in_fire;
    dgram_t push_word, head;

    // Only a last byte needs queue space; hold all bytes while full for simplicity.
    assign in_ready = !full;
    assign in_fire  = in_valid && in_ready;

    ierb_front u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .data_byte(data_byte), .last_byte(last_byte),
        .push(push), .push_word(push_word)
    );

    ierb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_word(push_word),
        .full(full), .not_empty(not_empty), .pop(pop), .head(head)
    );

    ierb_back u_back (
        .clk(clk), .rst_n(rst_n), .avail(not_empty), .head(head), .pop(pop),
        .out_valid(out_valid), .out_ready(out_ready),
        .verdict(verdict), .reply_checksum(reply_checksum),
        .reply_source(reply_source), .reply_destination(reply_destination),
        .icmp_length(icmp_length), .header_length(header_length)
    );
endmodule
